// ===== rtl/core/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg: calendar time breakdown shared types and constants
// Beat formats, constant reciprocals and the January 1 weekday table.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int YEAR_W  = 8;
  localparam int SECS_W  = 25;
  localparam int YDAY_W  = 9;
  localparam int REM_W   = 17;
  localparam int MINS_W  = 11;
  localparam int YEAR_CNT = 1 << YEAR_W;

  localparam logic [SECS_W-1:0] SECS_PER_DAY  = 25'd86400;
  localparam logic [SECS_W-1:0] SECS_YEAR     = 25'd31536000;
  localparam logic [SECS_W-1:0] SECS_LEAP_YR  = 25'd31622400;

  // 1900 and 2100 are the only century years in range that skip the leap day
  localparam logic [YEAR_W-1:0] YR_1900 = 8'd0;
  localparam logic [YEAR_W-1:0] YR_2100 = 8'd200;

  // floor(x / 675) for x < 2^18 is (x * DAY_RECIP) >> DAY_SHIFT
  localparam logic [18:0] DAY_RECIP  = 19'd397683;
  localparam int          DAY_SHIFT  = 28;
  // floor(x / 60) for x < 2^17 is (x * MIN_RECIP) >> MIN_SHIFT
  localparam logic [17:0] MIN_RECIP  = 18'd139811;
  localparam int          MIN_SHIFT  = 23;
  // floor(x / 60) for x < 1440 is (x * HOUR_RECIP) >> HOUR_SHIFT
  localparam logic [10:0] HOUR_RECIP = 11'd1093;
  localparam int          HOUR_SHIFT = 16;

  typedef struct packed {
    logic [7:0]  years_since_1900;
    logic [24:0] seconds_in_year;
  } ctb_in_t;

  typedef struct packed {
    logic [8:0] day_of_year;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [3:0] month_index;
    logic [4:0] month_day;
    logic [2:0] week_day;
    logic       leap_year;
    logic       bad_input;
  } ctb_out_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] mday;
    logic [2:0] wday;
  } cal_t;

  typedef logic [YEAR_CNT-1:0][2:0] jan1_tbl_t;

  function automatic jan1_tbl_t build_jan1_tbl();
    jan1_tbl_t tbl;
    int        g;
    int        k;
    int        base;
    int        extra;
    int        v;
    bit        lp;
    tbl = '0;
    for (int y = 0; y < YEAR_CNT; y++) begin
      g  = y + 1900;
      lp = ((g % 4 == 0) && (g % 100 != 0)) || (g % 400 == 0);
      base  = 0;
      extra = 0;
      if (y >= 4) begin
        k    = ((y / 4) * 5) % 7;
        base = (y < 204) ? k : k - 1;
      end
      if (y >= 200 && y < 204) begin
        extra = y % 4;
      end else if (!lp) begin
        extra = 1 + (y % 4);
      end
      v      = ((base + extra) % 7 + 7) % 7;
      tbl[y] = 3'(v);
    end
    return tbl;
  endfunction

  localparam jan1_tbl_t JAN1_WDAY = build_jan1_tbl();

endpackage

// ===== rtl/core/ctb_cal.sv =====
// ----------------------------------------------------------------------------
// ctb_cal: month, day of month and weekday from the day of the year
// Parallel compares against month start days; weekday by octal digit folding.
// ----------------------------------------------------------------------------
module ctb_cal (
  input  logic [8:0]    yday,
  input  logic          leap,
  input  logic [2:0]    jan1_wd,
  output ctb_pkg::cal_t cal
);
  import ctb_pkg::*;

  function automatic logic [8:0] month_first(input logic lp, input logic [3:0] m);
    logic [8:0] first;
    case (m)
      4'd0:    first = 9'd0;
      4'd1:    first = 9'd31;
      4'd2:    first = 9'd59;
      4'd3:    first = 9'd90;
      4'd4:    first = 9'd120;
      4'd5:    first = 9'd151;
      4'd6:    first = 9'd181;
      4'd7:    first = 9'd212;
      4'd8:    first = 9'd243;
      4'd9:    first = 9'd273;
      4'd10:   first = 9'd304;
      4'd11:   first = 9'd334;
      default: first = 9'd0;
    endcase
    if (lp && m >= 4'd2) begin
      first = first + 9'd1;
    end
    return first;
  endfunction

  logic [10:0] ge;
  logic [3:0]  month;
  logic [4:0]  wd_sum;
  logic [3:0]  wd_fold;

  always_comb begin
    for (int m = 1; m < 12; m++) begin
      ge[m-1] = (yday >= month_first(leap, 4'(m)));
    end
  end

  assign month = 4'($countones(ge));

  // 8 = 1 mod 7: fold octal digits
  assign wd_sum  = 5'(jan1_wd) + 5'(yday[8:6]) + 5'(yday[5:3]) + 5'(yday[2:0]);
  assign wd_fold = 4'(wd_sum[4:3]) + 4'(wd_sum[2:0]);

  always_comb begin
    cal.month = month;
    cal.mday  = 5'(yday - month_first(leap, month) + 9'd1);
    cal.wday  = (wd_fold >= 4'd7) ? 3'(wd_fold - 4'd7) : wd_fold[2:0];
  end

endmodule

// ===== rtl/core/calendar_time_breakdown.sv =====
// ----------------------------------------------------------------------------
// calendar_time_breakdown: seconds of year to broken-down calendar time
// Each input beat (year since 1900, seconds since January 1 00:00) gives one
// result beat with day of year, hour, minute, second, month, day of month,
// weekday, leap flag and an invalid flag for seconds beyond the year's end;
// on an invalid beat every field but the two flags reads zero. The block
// takes one beat per clock while the output is not stalled and presents its
// result through a five-register pipeline (input, day split, calendar, minute
// split, output), where each step between registers holds one wide constant
// multiply (the last step also two multiplies by 60); each stage holds its
// beat on its own, so bubbles close up while the output is stalled.
// ----------------------------------------------------------------------------
module calendar_time_breakdown (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ctb_pkg::ctb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ctb_pkg::ctb_out_t out_data
);
  import ctb_pkg::*;

  typedef struct packed {
    logic [SECS_W-1:0] secs;
    logic [YDAY_W-1:0] yday;
    logic [2:0]        jan1;
    logic              leap;
    logic              bad;
  } s1_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [YDAY_W-1:0] yday;
    cal_t              cal;
    logic              leap;
    logic              bad;
  } s2_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [MINS_W-1:0] mins;
    logic [YDAY_W-1:0] yday;
    cal_t              cal;
    logic              leap;
    logic              bad;
  } s3_t;

  ctb_in_t  in_r;
  s1_t      s1_r, s1_nxt;
  s2_t      s2_r, s2_nxt;
  s3_t      s3_r, s3_nxt;
  ctb_out_t out_r, out_nxt;

  logic in_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic ld_in, ld_s1, ld_s2, ld_s3, ld_out;
  logic free_in, free_s1, free_s2, free_s3;

  // Handshake
  assign ld_out  = s3_vld_r && (!out_vld_r || !out_stall);
  assign free_s3 = !s3_vld_r || ld_out;
  assign ld_s3   = s2_vld_r && free_s3;
  assign free_s2 = !s2_vld_r || ld_s3;
  assign ld_s2   = s1_vld_r && free_s2;
  assign free_s1 = !s1_vld_r || ld_s2;
  assign ld_s1   = in_vld_r && free_s1;
  assign free_in = !in_vld_r || ld_s1;
  assign ld_in   = in_valid && free_in;

  assign in_stall  = !free_in;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= ld_in  || (in_vld_r && !ld_s1);
      s1_vld_r  <= ld_s1  || (s1_vld_r && !ld_s2);
      s2_vld_r  <= ld_s2  || (s2_vld_r && !ld_s3);
      s3_vld_r  <= ld_s3  || (s3_vld_r && !ld_out);
      out_vld_r <= ld_out || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in) begin
      in_r <= in_data;
    end
    if (ld_s1) begin
      s1_r <= s1_nxt;
    end
    if (ld_s2) begin
      s2_r <= s2_nxt;
    end
    if (ld_s3) begin
      s3_r <= s3_nxt;
    end
    if (ld_out) begin
      out_r <= out_nxt;
    end
  end

  // Day split
  logic [36:0] day_prod;
  logic        in_leap;

  assign in_leap  = (in_r.years_since_1900[1:0] == 2'd0) &&
                    (in_r.years_since_1900 != YR_1900) &&
                    (in_r.years_since_1900 != YR_2100);
  assign day_prod = 37'(in_r.seconds_in_year[SECS_W-1:7]) * 37'(DAY_RECIP);

  always_comb begin
    s1_nxt.secs = in_r.seconds_in_year;
    s1_nxt.yday = day_prod[DAY_SHIFT +: YDAY_W];
    s1_nxt.jan1 = JAN1_WDAY[in_r.years_since_1900];
    s1_nxt.leap = in_leap;
    s1_nxt.bad  = in_r.seconds_in_year >= (in_leap ? SECS_LEAP_YR : SECS_YEAR);
  end

  // Calendar
  logic [25:0] day_base;
  cal_t        cal;

  assign day_base = 26'(s1_r.yday) * 26'(SECS_PER_DAY);

  ctb_cal u_cal (
    .yday    (s1_r.yday),
    .leap    (s1_r.leap),
    .jan1_wd (s1_r.jan1),
    .cal     (cal)
  );

  always_comb begin
    s2_nxt.rem  = REM_W'(s1_r.secs - day_base[SECS_W-1:0]);
    s2_nxt.yday = s1_r.yday;
    s2_nxt.cal  = cal;
    s2_nxt.leap = s1_r.leap;
    s2_nxt.bad  = s1_r.bad;
  end

  // Minute split
  logic [34:0] min_prod;

  assign min_prod = 35'(s2_r.rem) * 35'(MIN_RECIP);

  always_comb begin
    s3_nxt.rem  = s2_r.rem;
    s3_nxt.mins = min_prod[MIN_SHIFT +: MINS_W];
    s3_nxt.yday = s2_r.yday;
    s3_nxt.cal  = s2_r.cal;
    s3_nxt.leap = s2_r.leap;
    s3_nxt.bad  = s2_r.bad;
  end

  // Hour, minute, second
  logic [21:0]      hour_prod;
  logic [4:0]       hour;
  logic [REM_W-1:0] min_base;
  logic [MINS_W-1:0] hour_base;

  assign hour_prod = 22'(s3_r.mins) * 22'(HOUR_RECIP);
  assign hour      = hour_prod[HOUR_SHIFT +: 5];
  assign min_base  = REM_W'(s3_r.mins) * REM_W'(60);
  assign hour_base = MINS_W'(hour) * MINS_W'(60);

  always_comb begin
    out_nxt.day_of_year      = s3_r.yday;
    out_nxt.hour_of_day      = hour;
    out_nxt.minute_of_hour   = 6'(s3_r.mins - hour_base);
    out_nxt.second_of_minute = 6'(s3_r.rem - min_base);
    out_nxt.month_index      = s3_r.cal.month;
    out_nxt.month_day        = s3_r.cal.mday;
    out_nxt.week_day         = s3_r.cal.wday;
    out_nxt.leap_year        = s3_r.leap;
    out_nxt.bad_input        = s3_r.bad;
    if (s3_r.bad) begin
      out_nxt           = '0;
      out_nxt.leap_year = s3_r.leap;
      out_nxt.bad_input = 1'b1;
    end
  end

  // Checks
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && s1_vld_r && s2_vld_r && s3_vld_r && out_vld_r && out_stall) |-> in_stall)
    else $error("full stalled pipeline does not stall input");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> !in_stall)
    else $error("input stalled with empty input stage");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_input) |->
      (out_data.day_of_year == 9'd0 && out_data.month_day == 5'd0 &&
       out_data.hour_of_day == 5'd0 && out_data.week_day == 3'd0))
    else $error("invalid beat carries nonzero fields");

  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.bad_input) |->
      (out_data.hour_of_day < 5'd24 && out_data.minute_of_hour < 6'd60 &&
       out_data.second_of_minute < 6'd60 && out_data.week_day < 3'd7 &&
       out_data.month_index < 4'd12 && out_data.month_day != 5'd0))
    else $error("result field out of range");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: calendar time breakdown testbench
// Drives year/seconds beats through the block with random sender gaps and
// receiver stalls, predicts each broken-down result (day, time of day, month,
// day of month, weekday, leap and invalid flags) and checks the result beats
// in order against the predictions.
// ----------------------------------------------------------------------------
module tb_top;
  import ctb_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RANDOM_BEATS  = 1950;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PCT      = 21;
  localparam int SECS_DAY      = 86400;
  localparam int SECS_ALL_ONES = (1 << 25) - 1;

  class breakdown_ledger;
    ctb_out_t expected_breakdowns[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function bit is_leap_year(int yr);
      int gy;
      gy = yr + 1900;
      return ((gy % 4 == 0) && (gy % 100 != 0)) || (gy % 400 == 0);
    endfunction

    static function ctb_out_t break_down_time(ctb_in_t beat);
      ctb_out_t r;
      int       yr;
      int       secs;
      int       yday;
      int       rem;
      int       mon;
      int       dleft;
      int       k;
      int       base;
      int       extra;
      int       wd;
      bit       lp;
      int       mlen[12];
      yr   = int'(beat.years_since_1900);
      secs = int'(beat.seconds_in_year);
      lp   = is_leap_year(yr);
      r    = '0;
      r.leap_year = lp;
      if (secs >= (lp ? 366 : 365) * SECS_DAY) begin
        r.bad_input = 1'b1;
        return r;
      end
      mlen  = '{31, lp ? 29 : 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      yday  = secs / SECS_DAY;
      rem   = secs % SECS_DAY;
      mon   = 0;
      dleft = yday;
      while (mon < 11 && dleft >= mlen[mon]) begin
        dleft -= mlen[mon];
        mon++;
      end
      base  = 0;
      extra = 0;
      if (yr >= 4) begin
        k    = ((yr / 4) * 5) % 7;
        base = (yr < 204) ? k : k - 1;
      end
      if (yr >= 200 && yr < 204) begin
        extra = yr % 4;
      end else if (!lp) begin
        extra = 1 + (yr % 4);
      end
      wd = (base + extra + yday) % 7;
      if (wd < 0) begin
        wd += 7;
      end
      r.day_of_year      = 9'(yday);
      r.hour_of_day      = 5'(rem / 3600);
      r.minute_of_hour   = 6'((rem % 3600) / 60);
      r.second_of_minute = 6'(rem % 60);
      r.month_index      = 4'(mon);
      r.month_day        = 5'(dleft + 1);
      r.week_day         = 3'(wd);
      r.bad_input        = 1'b0;
      return r;
    endfunction

    function void note_timestamp(ctb_in_t beat);
      expected_breakdowns.push_back(break_down_time(beat));
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_breakdown(ctb_out_t got);
      ctb_out_t exp_r;
      if (expected_breakdowns.size() == 0) begin
        $error("unexpected result beat %h", got);
        mismatches++;
        return;
      end
      exp_r = expected_breakdowns.pop_front();
      compare_field("day_of_year", exp_r.day_of_year, got.day_of_year);
      compare_field("hour_of_day", exp_r.hour_of_day, got.hour_of_day);
      compare_field("minute_of_hour", exp_r.minute_of_hour, got.minute_of_hour);
      compare_field("second_of_minute", exp_r.second_of_minute, got.second_of_minute);
      compare_field("month_index", exp_r.month_index, got.month_index);
      compare_field("month_day", exp_r.month_day, got.month_day);
      compare_field("week_day", exp_r.week_day, got.week_day);
      compare_field("leap_year", exp_r.leap_year, got.leap_year);
      compare_field("bad_input", exp_r.bad_input, got.bad_input);
    endfunction

    function int pending();
      return expected_breakdowns.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ctb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ctb_out_t out_data;

  bit              steady = 1'b0;
  int unsigned     cycle_count = 0;
  breakdown_ledger ledger = new();

  calendar_time_breakdown DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      ledger.note_timestamp(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      ledger.check_breakdown(out_data);
    end
  end

  task automatic send_timestamp(int yr, int secs);
    ctb_in_t beat;
    beat.years_since_1900 = 8'(yr);
    beat.seconds_in_year  = 25'(secs);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (ledger.pending() != 0);
  endtask

  task automatic send_random_timestamp();
    int yr;
    int year_secs;
    int pick;
    int secs;
    int day;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(6))
        0: yr = 0;
        1: yr = 100;
        2: yr = 200;
        3: yr = 203;
        4: yr = 204;
        5: yr = 205;
        default: yr = 255;
      endcase
    end else begin
      yr = $urandom_range(255);
    end
    year_secs = (breakdown_ledger::is_leap_year(yr) ? 366 : 365) * SECS_DAY;
    pick = $urandom_range(99);
    if (pick < 70) begin
      secs = $urandom_range(year_secs - 1);
    end else if (pick < 88) begin
      day = $urandom_range((year_secs / SECS_DAY) - 1);
      case ($urandom_range(2))
        0: secs = day * SECS_DAY;
        1: secs = day * SECS_DAY + SECS_DAY - 1;
        default: secs = day * SECS_DAY + $urandom_range(59);
      endcase
    end else if (pick < 92) begin
      secs = year_secs - 1 + $urandom_range(1);
    end else begin
      secs = $urandom_range(SECS_ALL_ONES, year_secs);
    end
    send_timestamp(yr, secs);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_timestamp(0, 0);
    send_timestamp(255, SECS_ALL_ONES);
    send_timestamp(0, 31535999);
    send_timestamp(0, 31536000);
    send_timestamp(100, 31622399);
    send_timestamp(100, 31622400);
    send_timestamp(124, 59 * SECS_DAY);
    send_timestamp(124, 58 * SECS_DAY + SECS_DAY - 1);
    send_timestamp(123, 59 * SECS_DAY);
    send_timestamp(200, 0);
    send_timestamp(200, 31535999);
    send_timestamp(200, 31536000);
    send_timestamp(203, 0);
    send_timestamp(204, 0);
    send_timestamp(204, 31622399);
    send_timestamp(205, 0);
    send_timestamp(206, 12345678);
    send_timestamp(255, 0);
    send_timestamp(255, 31535999);
    send_timestamp(255, 31536000);
    send_timestamp(128, 31622399);
    send_timestamp(101, 13 * 3600 + 7 * 60 + 42);
    send_timestamp(0, SECS_ALL_ONES);
    send_timestamp(170, 334 * SECS_DAY);
    hold_until_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      steady = (n >= 700 && n < 1000);
      if (n == 1300) begin
        hold_until_drained();
      end
      send_random_timestamp();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    do begin
      @(posedge clk);
    end while (ledger.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
